>>> rtl/lkc_pkg.sv
// Shared types and constants for the keyed LRU cache.
`timescale 1ns / 1ps

package lkc_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int LEN_W    = 4;
    localparam int VAL_W    = 32;
    localparam int CFG_W    = 6;
    localparam int CFG_RST  = 32;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic load;
        logic match;
        logic commit;
    } t_ctrl_cmd;

endpackage

>>> rtl/lkc_ctrl.sv
// Controller: sequences each transfer through match and update, owns output valid.
`timescale 1ns / 1ps

module lkc_ctrl
    import lkc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  logic      i_ready,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   can_commit;

    assign can_commit = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_MATCH;
            end
            S_MATCH: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (can_commit) n_state = i_valid ? S_MATCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd.match  = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
            end
            S_UPDATE: begin
                o_ready      = can_commit;
                o_cmd.commit = can_commit;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
        o_cmd.load = o_ready && i_valid;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> rtl/lkc_datapath.sv
// Datapath: entry registers, key compare, recency ranks and result register.
`timescale 1ns / 1ps

module lkc_datapath
    import lkc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctrl_cmd        i_cmd,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_opcode,
    input  logic [KEY_W-1:0] i_key,
    input  logic [LEN_W-1:0] i_key_length,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_hit,
    output logic [VAL_W-1:0] o_value_out,
    output logic             o_evicted,
    output logic [5:0]       o_entry_count
);

    logic [CFG_W-1:0] r_max;

    // latched request
    t_opcode          r_op;
    logic [KEY_W-1:0] r_key;
    logic [LEN_W-1:0] r_len;
    logic [VAL_W-1:0] r_val;
    logic [KEY_W-1:0] key_masked;

    // entries
    logic [KEY_W-1:0] r_key_st [CAPACITY];
    logic [LEN_W-1:0] r_len_st [CAPACITY];
    logic [VAL_W-1:0] r_val_st [CAPACITY];
    logic [IDX_W-1:0] r_rank   [CAPACITY];
    logic [IDX_W-1:0] n_rank   [CAPACITY];
    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] n_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;

    // match stage
    logic [CAPACITY-1:0] n_match;
    logic [CAPACITY-1:0] r_match;
    logic [CAPACITY-1:0] n_keep;
    logic [CAPACITY-1:0] r_keep;
    logic [IDX_W-1:0]    n_slot;
    logic [IDX_W-1:0]    r_slot;
    logic [CNT_W-1:0]    lim;
    logic [CNT_W-1:0]    r_lim;
    logic                n_evict;
    logic                r_evict;

    // update stage
    logic [CAPACITY-1:0] rank_hot;
    logic [IDX_W-1:0]    best;
    logic [CAPACITY-1:0] found;
    logic                hit;
    logic [VAL_W-1:0]    hit_val;

    // result
    logic             r_hit;
    logic [VAL_W-1:0] r_value_out;
    logic             r_evicted;

    always_comb begin
        for (int b = 0; b < KEY_W / 8; b++) begin
            key_masked[b*8 +: 8] = (LEN_W'(b) < i_key_length) ? i_key[b*8 +: 8] : 8'h00;
        end
    end

    always_comb begin
        if (r_max == '0) begin
            lim = CNT_W'(1);
        end else if ({{(32-CFG_W){1'b0}}, r_max} > 32'(CAPACITY)) begin
            lim = CNT_W'(CAPACITY);
        end else begin
            lim = CNT_W'(r_max);
        end
        n_evict = (r_count >= lim);
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_match[i] = r_valid[i] && (r_len_st[i] == r_len) && (r_key_st[i] == r_key);
            n_keep[i]  = r_valid[i] &&
                         !(n_evict && ({1'b0, r_rank[i]} >= CNT_W'(lim - 1'b1)));
        end
        n_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!n_keep[i]) n_slot = IDX_W'(i);
        end
    end

    // ranks of valid entries are distinct, so the lowest matching rank picks one entry
    always_comb begin
        for (int r = 0; r < CAPACITY; r++) begin
            rank_hot[r] = 1'b0;
            for (int i = 0; i < CAPACITY; i++) begin
                if (r_match[i] && (r_rank[i] == IDX_W'(r))) rank_hot[r] = 1'b1;
            end
        end
        best = '0;
        for (int r = CAPACITY - 1; r >= 0; r--) begin
            if (rank_hot[r]) best = IDX_W'(r);
        end
        hit     = |r_match;
        hit_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found[i] = r_match[i] && (r_rank[i] == best);
            if (found[i]) hit_val = hit_val | r_val_st[i];
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < CAPACITY; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (r_op == OP_INSERT) begin
            n_valid = r_keep;
            n_valid[r_slot] = 1'b1;
            n_count = r_evict ? CNT_W'(r_lim + 1'b1) : CNT_W'(r_count + 1'b1);
            for (int i = 0; i < CAPACITY; i++) begin
                if (IDX_W'(i) == r_slot) begin
                    n_rank[i] = '0;
                end else if (r_keep[i]) begin
                    n_rank[i] = IDX_W'(r_rank[i] + 1'b1);
                end
            end
        end else if (hit) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (found[i]) begin
                    n_rank[i] = '0;
                end else if (r_valid[i] && (r_rank[i] < best)) begin
                    n_rank[i] = IDX_W'(r_rank[i] + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= CFG_W'(CFG_RST);
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) r_max <= i_cfg_data;
            if (i_cmd.commit) begin
                r_valid <= n_valid;
                r_count <= n_count;
                for (int i = 0; i < CAPACITY; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_opcode'(i_opcode);
            r_key <= key_masked;
            r_len <= i_key_length;
            r_val <= i_value;
        end
        if (i_cmd.match) begin
            r_match <= n_match;
            r_keep  <= n_keep;
            r_slot  <= n_slot;
            r_lim   <= CNT_W'(lim - 1'b1);
            r_evict <= n_evict;
        end
        if (i_cmd.commit) begin
            if (r_op == OP_INSERT) begin
                r_key_st[r_slot] <= r_key;
                r_len_st[r_slot] <= r_len;
                r_val_st[r_slot] <= r_val;
            end
            r_hit       <= (r_op == OP_LOOKUP) && hit;
            r_value_out <= ((r_op == OP_LOOKUP) && hit) ? hit_val : '0;
            r_evicted   <= (r_op == OP_INSERT) && r_evict;
        end
    end

    // after eviction lim-1 entries stay, then the insert adds one
    assign o_hit         = r_hit;
    assign o_value_out   = r_value_out;
    assign o_evicted     = r_evicted;
    assign o_entry_count = 6'(r_count);

`ifndef SYNTHESIS
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count))
        else $error("entry count disagrees with valid marks");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && (r_op == OP_LOOKUP) |-> $onehot0(found))
        else $error("recency ranks not distinct among matches");

    a_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && (r_op == OP_INSERT) |-> !(&r_keep))
        else $error("insert without a free slot");
`endif

endmodule

>>> rtl/lru_keyed_cache_unit.sv
// Top level of the keyed LRU cache: controller and datapath.
`timescale 1ns / 1ps

// Fully associative 32-entry cache with least-recently-used replacement, keyed by
// up to eight key bytes plus the key length. Each transfer passes a match state,
// which compares the key against all entries in parallel and picks the free slot
// and eviction set, then an update state, which resolves the most recent match,
// updates the recency ranks and loads the result register. A new transfer is
// taken in the update state as the previous one commits, while results are taken;
// a held result stalls the update state. Reset clears the valid marks.
// max_entries may be written only while the block is idle; 0 acts as 1 and values
// above 32 act as 32.

module lru_keyed_cache_unit
    import lkc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_opcode,
    input  logic [KEY_W-1:0] i_key,
    input  logic [LEN_W-1:0] i_key_length,
    input  logic [VAL_W-1:0] i_value,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_hit,
    output logic [VAL_W-1:0] o_value_out,
    output logic             o_evicted,
    output logic [5:0]       o_entry_count
);

    t_ctrl_cmd cmd;

    lkc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    lkc_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_key_length  (i_key_length),
        .i_value       (i_value),
        .o_hit         (o_hit),
        .o_value_out   (o_value_out),
        .o_evicted     (o_evicted),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for lru_keyed_cache_unit: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
    import lkc_pkg::*;

    localparam int DIRECTED_ROWS = 23;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 120;
    localparam int KEY_POOL      = 12;
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value_out;
        logic             evicted;
        logic [5:0]       entry_count;
    } t_result;

    typedef struct packed {
        t_opcode          op;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] value;
        logic             typed;
        t_result          want;
    } t_row;

    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_cfg_we     = 1'b0;
    logic [CFG_W-1:0] i_cfg_data   = '0;
    logic             i_valid      = 1'b0;
    logic             o_ready;
    logic             i_opcode     = 1'b0;
    logic [KEY_W-1:0] i_key        = '0;
    logic [LEN_W-1:0] i_key_length = '0;
    logic [VAL_W-1:0] i_value      = '0;
    logic             o_valid;
    logic             i_ready      = 1'b0;
    logic             o_hit;
    logic [VAL_W-1:0] o_value_out;
    logic             o_evicted;
    logic [5:0]       o_entry_count;

    lru_keyed_cache_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_key_length  (i_key_length),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit         (o_hit),
        .o_value_out   (o_value_out),
        .o_evicted     (o_evicted),
        .o_entry_count (o_entry_count)
    );

    // cache shadow
    logic [KEY_W-1:0] cache_key  [CAPACITY];
    logic [LEN_W-1:0] cache_len  [CAPACITY];
    logic [VAL_W-1:0] cache_val  [CAPACITY];
    int               cache_rank [CAPACITY];
    bit               cache_live [CAPACITY];
    int               cache_count;
    logic [CFG_W-1:0] cache_limit;

    t_result pending_results[$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      send_idle_pct  = 20;
    int      recv_stall_pct = 20;
    int      stall_left     = 0;

    t_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_LOOKUP, 64'h0,                  4'd0 + 4'd1, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd0}},
        '{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  32'hFFFF_FFFF, 1'b1,
          '{1'b0, 32'h0, 1'b0, 6'd1}},
        '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  32'h0, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 1'b0, 6'd1}},
        '{OP_INSERT, 64'h0,                  4'd0,  32'h0, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd2}},
        '{OP_LOOKUP, 64'hDEAD_BEEF,          4'd0,  32'h0, 1'b1, '{1'b1, 32'h0, 1'b0, 6'd2}},
        '{OP_INSERT, 64'h11,                 4'd1,  32'hA1, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd3}},
        '{OP_INSERT, 64'hFF11,               4'd1,  32'hA2, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd4}},
        '{OP_LOOKUP, 64'h3311,               4'd1,  32'h0, 1'b1, '{1'b1, 32'hA2, 1'b0, 6'd4}},
        '{OP_LOOKUP, 64'h11,                 4'd2,  32'h0, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd4}},
        '{OP_INSERT, 64'h0123_4567_89AB_CDEF, 4'd15, 32'h8000_0000, 1'b1,
          '{1'b0, 32'h0, 1'b0, 6'd5}},
        '{OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd15, 32'h0, 1'b1,
          '{1'b1, 32'h8000_0000, 1'b0, 6'd5}},
        '{OP_LOOKUP, 64'h0123_4567_89AB_CDEF, 4'd8,  32'h0, 1'b1,
          '{1'b0, 32'h0, 1'b0, 6'd5}},
        '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF11, 4'd1,  32'h0, 1'b1,
          '{1'b1, 32'hA2, 1'b0, 6'd5}},
        '{OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  32'h5555_5555, 1'b1,
          '{1'b0, 32'h0, 1'b0, 6'd6}},
        '{OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8,  32'h0, 1'b1,
          '{1'b1, 32'h5555_5555, 1'b0, 6'd6}},
        '{OP_LOOKUP, 64'h5555_5555_5555_5555, 4'd8,  32'h0, 1'b1,
          '{1'b0, 32'h0, 1'b0, 6'd6}},
        '{OP_INSERT, 64'h0,                  4'd15, 32'h0, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd7}},
        '{OP_LOOKUP, 64'h0,                  4'd8,  32'h0, 1'b1, '{1'b0, 32'h0, 1'b0, 6'd7}},
        '{OP_INSERT, 64'h1234,               4'd2,  32'h1, 1'b0, '0},
        '{OP_LOOKUP, 64'hFFFF_0000_0000_1234, 4'd2,  32'h0, 1'b0, '0},
        '{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  32'h0, 1'b0, '0},
        '{OP_INSERT, 64'h8000_0000_0000_0000, 4'd9,  32'h7FFF_FFFF, 1'b0, '0},
        '{OP_LOOKUP, 64'h8000_0000_0000_0000, 4'd9,  32'h0, 1'b0, '0}
    };

    logic [CFG_W-1:0] phase_limit [PHASES] = '{
        6'd32, 6'd1, 6'd0, 6'd63, 6'd3, 6'd32, 6'd33, 6'd2, 6'd17, 6'd32
    };
    int phase_idle [PHASES] = '{25, 25, 40, 0, 25, 10, 25, 40, 25, 0};

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        if (len >= 4'd8)
            return '1;
        return (64'd1 << {len, 3'b000}) - 64'd1;
    endfunction

    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(9);
        if (r < 8)
            return LEN_W'(r + 1);
        if (r == 8)
            return '0;
        return LEN_W'($urandom_range(15, 9));
    endfunction

    function automatic t_result cache_access(input t_opcode op, input logic [KEY_W-1:0] key,
                                             input logic [LEN_W-1:0] len,
                                             input logic [VAL_W-1:0] value);
        t_result          r;
        logic [KEY_W-1:0] k;
        int               found;
        int               best;
        int               lim;
        int               slot;
        r = '0;
        k = key & byte_mask(len);
        if (op == OP_LOOKUP) begin
            found = -1;
            best = 0;
            for (int i = 0; i < CAPACITY; i++) begin
                if (cache_live[i] && cache_len[i] == len && cache_key[i] == k) begin
                    if (found < 0 || cache_rank[i] < best) begin
                        found = i;
                        best = cache_rank[i];
                    end
                end
            end
            if (found >= 0) begin
                r.hit = 1'b1;
                r.value_out = cache_val[found];
                for (int i = 0; i < CAPACITY; i++)
                    if (cache_live[i] && cache_rank[i] < best)
                        cache_rank[i]++;
                cache_rank[found] = 0;
            end
        end else begin
            lim = (cache_limit == 0) ? 1 : (cache_limit > CAPACITY) ? CAPACITY : cache_limit;
            slot = -1;
            if (cache_count >= lim) begin
                // drop everything ranked at or past the new tail
                r.evicted = 1'b1;
                cache_count = 0;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (cache_live[i] && cache_rank[i] >= lim - 1)
                        cache_live[i] = 1'b0;
                    if (cache_live[i])
                        cache_count++;
                end
            end
            for (int i = 0; i < CAPACITY; i++) begin
                if (cache_live[i])
                    cache_rank[i]++;
                else if (slot < 0)
                    slot = i;
            end
            if (slot >= 0) begin
                cache_key[slot] = k;
                cache_len[slot] = len;
                cache_val[slot] = value;
                cache_rank[slot] = 0;
                cache_live[slot] = 1'b1;
                cache_count++;
            end
        end
        r.entry_count = cache_count[5:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < 40)
            $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatch_count++;
    endtask

    task automatic send_request(input t_opcode op, input logic [KEY_W-1:0] key,
                                input logic [LEN_W-1:0] len, input logic [VAL_W-1:0] value,
                                input logic typed, input t_result want);
        t_result pred;
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_key        <= key;
        i_key_length <= len;
        i_value      <= value;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pred = cache_access(op, key, len, value);
        pending_results.push_back(typed ? want : pred);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(5, 1))
                @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected result", 64'(o_entry_count), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit)
                    flag_mismatch("hit", 64'(o_hit), 64'(want.hit));
                if (o_value_out !== want.value_out)
                    flag_mismatch("value_out", 64'(o_value_out), 64'(want.value_out));
                if (o_evicted !== want.evicted)
                    flag_mismatch("evicted", 64'(o_evicted), 64'(want.evicted));
                if (o_entry_count !== want.entry_count)
                    flag_mismatch("entry_count", 64'(o_entry_count), 64'(want.entry_count));
            end
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
            i_ready <= 1'b0;
            stall_left = $urandom_range(4);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("lru_keyed_cache_unit regression: fail");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        logic [KEY_W-1:0] pool_key [KEY_POOL];
        logic [LEN_W-1:0] pool_len [KEY_POOL];
        t_opcode          op;
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        int               j;
        for (int p = 0; p < KEY_POOL; p++) begin
            pool_key[p] = {$urandom, $urandom};
            pool_len[p] = pick_length();
        end
        for (int i = 0; i < CAPACITY; i++) begin
            cache_rank[i] = 0;
            cache_live[i] = 1'b0;
        end
        cache_count = 0;
        cache_limit = CFG_W'(CFG_RST);

        repeat (10)
            @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_request(directed_rows[r].op, directed_rows[r].key, directed_rows[r].len,
                         directed_rows[r].value, directed_rows[r].typed, directed_rows[r].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            i_valid <= 1'b0;
            drain_results();
            i_cfg_we   <= 1'b1;
            i_cfg_data <= phase_limit[ph];
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            cache_limit = phase_limit[ph];
            send_idle_pct  = phase_idle[ph];
            recv_stall_pct = phase_idle[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(1) != 0) ? OP_INSERT : OP_LOOKUP;
                j = $urandom_range(KEY_POOL - 1);
                if (op == OP_INSERT && $urandom_range(2) == 0) begin
                    pool_key[j] = {$urandom, $urandom};
                    pool_len[j] = pick_length();
                end
                key = pool_key[j];
                len = pool_len[j];
                // junk above the key length must not matter
                if ($urandom_range(3) == 0)
                    key = (key & byte_mask(len)) | ({$urandom, $urandom} & ~byte_mask(len));
                if (op == OP_LOOKUP && $urandom_range(4) == 0) begin
                    key = {$urandom, $urandom};
                    len = pick_length();
                end
                send_request(op, key, len, $urandom, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        drain_results();
        repeat (8)
            @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("lru_keyed_cache_unit regression: pass");
        else
            $display("lru_keyed_cache_unit regression: fail");
        $finish;
    end

endmodule
